/* sv/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// transaction payloads, memory words, write requests, codes and helpers
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int PAGE_W     = 10;
    localparam int RANK_LIMIT = 16;
    localparam int LIST_IDX_W = 4;
    localparam int LINK_W     = 11;
    localparam int CNT_W      = 11;

    // largest pool rank whose pool fits in POOL_PAGES
    localparam logic [3:0]        ACT_MAX    = 4'd11;
    localparam logic [LINK_W-1:0] LINK_NIL   = 11'h7FF;

    // operation codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_QRANK  = 3'd3;
    localparam logic [2:0] OP_QCOUNT = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  rank;
        logic [15:0] page;
    } bpa_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  page_out;
        logic [10:0] value;
    } bpa_rsp_t;

    // per-page word: allocated block start, allocated rank, free block rank
    typedef struct packed {
        logic       bs;
        logic [4:0] ar;
        logic [4:0] fr;
    } page_word_t;

    // per-page free list links, nil has the top bit set
    typedef struct packed {
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
    } link_word_t;

    typedef struct packed {
        logic              en_alloc;
        logic              en_free;
        logic [PAGE_W-1:0] addr;
        page_word_t        data;
    } page_wr_t;

    typedef struct packed {
        logic              en_nx;
        logic              en_pv;
        logic [PAGE_W-1:0] addr;
        link_word_t        data;
    } link_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ASRCH,
        S_UNL_DAT,
        S_UNL_PV,
        S_ASPLIT,
        S_PUSH1,
        S_PUSH2,
        S_AFILL,
        S_FRD,
        S_FCLR,
        S_FMRG,
        S_FCHK,
        S_QRD,
        S_QWALK
    } bpa_state_t;

    // pages spanned by a block of rank r
    function automatic logic [CNT_W-1:0] blk_pages(input logic [4:0] r);
        blk_pages = CNT_W'(1) << (r - 5'd1);
    endfunction

    // effective pool rank from the register value
    function automatic logic [3:0] act_of(input logic [3:0] pr);
        if (pr == 4'd0)
        begin
            act_of = 4'd1;
        end
        else if (pr > ACT_MAX)
        begin
            act_of = ACT_MAX;
        end
        else
        begin
            act_of = pr;
        end
    endfunction

    // largest rank whose block fits in a run of free pages
    function automatic logic [4:0] run_rank(input logic [CNT_W-1:0] run);
        logic [4:0] r;
        r = 5'd1;
        for (int i = 1; i < CNT_W; i++)
        begin
            if (run >= (CNT_W'(1) << i))
            begin
                r = 5'(i + 1);
            end
        end
        run_rank = r;
    endfunction

endpackage

/* sv/buddy_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// buddy_page_allocator_core: buddy page allocator over a 1024-page pool
// sequencer over a page rank memory and a free list link memory
// ----------------------------------------------------------------------------
//  channel   | signals                      | transaction
//  ----------+------------------------------+---------------------------------
//  command   | start, busy, cmd             | start high while busy low
//  result    | done, result                 | done high for one cycle
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
//  query count, invalid commands: result in the cycle after the command is
//    taken; a free of a page that starts no block is refused in S_FRD.
//  alloc: searches the lists upward, unlinks the block found, splits it down,
//    pushing each upper half, then marks every page of the block.
//  free: clears every page of the block, merges with free buddies, pushes it.
//  query rank: scans the free run page by page, up to 1024 pages.
//  reset and init sweep all 1024 page memory words with busy high.
//  results cannot be stalled; config is taken in any cycle.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  bpa_cmd_t   cmd,
    output logic       busy,
    output logic       done,
    output bpa_rsp_t   result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    logic [PAGE_W-1:0] a_raddr;
    page_word_t        a_rdata;
    page_wr_t          a_wr;
    logic [PAGE_W-1:0] b_raddr;
    link_word_t        b_rdata;
    link_wr_t          b_wr;

    // config register always accepts
    assign cfg_ready = 1'b1;

    // sequencer
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .a_raddr   (a_raddr),
        .a_rdata   (a_rdata),
        .a_wr      (a_wr),
        .b_raddr   (b_raddr),
        .b_rdata   (b_rdata),
        .b_wr      (b_wr)
    );

    // per-page ranks
    bpa_page_mem u_page_mem (
        .clk   (clk),
        .raddr (a_raddr),
        .rdata (a_rdata),
        .wr    (a_wr)
    );

    // free list links
    bpa_link_mem u_link_mem (
        .clk   (clk),
        .raddr (b_raddr),
        .rdata (b_rdata),
        .wr    (b_wr)
    );

endmodule

/* sv/bpa_page_mem.sv */
// ----------------------------------------------------------------------------
// bpa_page_mem: per-page rank memory
// one read port with registered data, one write port with field enables
// ----------------------------------------------------------------------------
module bpa_page_mem
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic [PAGE_W-1:0] raddr,
    output page_word_t        rdata,
    input  page_wr_t          wr
);

    page_word_t mem [POOL_PAGES];

    // field-masked write, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en_alloc)
        begin
            mem[wr.addr].bs <= wr.data.bs;
            mem[wr.addr].ar <= wr.data.ar;
        end
        if (wr.en_free)
        begin
            mem[wr.addr].fr <= wr.data.fr;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/bpa_link_mem.sv */
// ----------------------------------------------------------------------------
// bpa_link_mem: free list link memory
// one read port with registered data, one write port with field enables
// ----------------------------------------------------------------------------
module bpa_link_mem
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic [PAGE_W-1:0] raddr,
    output link_word_t        rdata,
    input  link_wr_t          wr
);

    link_word_t mem [POOL_PAGES];

    // field-masked write, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en_nx)
        begin
            mem[wr.addr].nx <= wr.data.nx;
        end
        if (wr.en_pv)
        begin
            mem[wr.addr].pv <= wr.data.pv;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl: allocator sequencer
// walks the page and link memories, owns list heads, counts and results
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bpa_cmd_t          cmd,
    output logic              busy,
    output logic              done,
    output bpa_rsp_t          result,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_data,
    output logic [PAGE_W-1:0] a_raddr,
    input  page_word_t        a_rdata,
    output page_wr_t          a_wr,
    output logic [PAGE_W-1:0] b_raddr,
    input  link_word_t        b_rdata,
    output link_wr_t          b_wr
);

    bpa_state_t state_reg, state_next;

    logic [2:0]        op_reg, op_next;
    logic [4:0]        rank_reg, rank_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [4:0]        c_reg, c_next;
    logic [PAGE_W-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PAGE_W-1:0] unl_p_reg, unl_p_next;
    logic [4:0]        unl_r_reg, unl_r_next;
    logic [PAGE_W-1:0] psh_p_reg, psh_p_next;
    logic [4:0]        psh_r_reg, psh_r_next;
    logic [LINK_W-1:0] psh_h_reg, psh_h_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic [LINK_W-1:0] pv_reg, pv_next;
    logic [3:0]        act_reg, act_next;
    logic [3:0]        pool_rank_reg;
    logic              clr_rsp_reg, clr_rsp_next;
    logic              done_reg, done_next;
    bpa_rsp_t          rsp_reg, rsp_next;

    logic [LINK_W-1:0] head_reg [RANK_LIMIT];
    logic [CNT_W-1:0]  lcount_reg [RANK_LIMIT];

    logic [LIST_IDX_W-1:0] lst_idx;
    logic [LINK_W-1:0]     lst_head;
    logic [CNT_W-1:0]      lst_cnt;
    logic                  lst_we_head;
    logic [LINK_W-1:0]     lst_head_wd;
    logic                  lst_we_cnt;
    logic [CNT_W-1:0]      lst_cnt_wd;
    logic                  init_lists;

    logic [CNT_W-1:0]  pages;
    logic              cmd_page_ok;
    logic              cmd_rank_ok;
    logic              c_in_pool;
    logic              c_below_act;
    logic              split_more;
    logic [4:0]        c_dn;
    logic [PAGE_W-1:0] split_p;
    logic [PAGE_W-1:0] buddy;
    logic              fill_last;
    logic              fclr_last;
    logic [CNT_W-1:0]  qsum;
    logic              q_end;
    logic              clr_last;

    // derived conditions
    assign pages       = CNT_W'(1) << (act_reg - 4'd1);
    assign cmd_page_ok = cmd.page < {5'b0, pages};
    assign cmd_rank_ok = (cmd.rank != 5'd0) && (cmd.rank <= 5'(RANK_LIMIT));
    assign c_in_pool   = c_reg <= {1'b0, act_reg};
    assign c_below_act = c_reg < {1'b0, act_reg};
    assign split_more  = c_reg > rank_reg;
    assign c_dn        = c_reg - 5'd1;
    assign split_p     = blk_reg + PAGE_W'(blk_pages(c_dn));
    assign buddy       = blk_reg ^ PAGE_W'(blk_pages(c_reg));
    assign fill_last   = cnt_reg == (blk_pages(rank_reg) - CNT_W'(1));
    assign fclr_last   = cnt_reg == (blk_pages(c_reg) - CNT_W'(1));
    assign qsum        = {1'b0, page_reg} + cnt_reg + CNT_W'(1);
    assign q_end       = qsum >= pages;
    assign clr_last    = cnt_reg[PAGE_W-1:0] == {PAGE_W{1'b1}};

    // single list port: index chosen by state
    always_comb
    begin
        case (state_reg)
            S_ASRCH:   lst_idx = LIST_IDX_W'(c_reg - 5'd1);
            S_PUSH1:   lst_idx = LIST_IDX_W'(psh_r_reg - 5'd1);
            S_UNL_DAT: lst_idx = LIST_IDX_W'(unl_r_reg - 5'd1);
            default:   lst_idx = LIST_IDX_W'(cmd.rank - 5'd1);
        endcase
    end

    assign lst_head = head_reg[lst_idx];
    assign lst_cnt  = lcount_reg[lst_idx];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.operation)
                        OP_INIT:  state_next = S_CLEAR;
                        OP_ALLOC: state_next = cmd_rank_ok ? S_ASRCH : S_IDLE;
                        OP_FREE:  state_next = cmd_page_ok ? S_FRD : S_IDLE;
                        OP_QRANK: state_next = cmd_page_ok ? S_QRD : S_IDLE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:   state_next = clr_last ? S_IDLE : S_CLEAR;
            S_ASRCH:
            begin
                if (!c_in_pool)
                begin
                    state_next = S_IDLE;
                end
                else if (!lst_head[LINK_W-1])
                begin
                    state_next = S_UNL_DAT;
                end
            end
            S_UNL_DAT: state_next = S_UNL_PV;
            S_UNL_PV:  state_next = (op_reg == OP_ALLOC) ? S_ASPLIT : S_FMRG;
            S_ASPLIT:  state_next = split_more ? S_PUSH1 : S_AFILL;
            S_PUSH1:   state_next = S_PUSH2;
            S_PUSH2:   state_next = (op_reg == OP_ALLOC) ? S_ASPLIT : S_IDLE;
            S_AFILL:   state_next = fill_last ? S_IDLE : S_AFILL;
            S_FRD:     state_next = a_rdata.bs ? S_FCLR : S_IDLE;
            S_FCLR:    state_next = fclr_last ? S_FMRG : S_FCLR;
            S_FMRG:    state_next = c_below_act ? S_FCHK : S_PUSH1;
            S_FCHK:    state_next = (a_rdata.fr == c_reg) ? S_UNL_DAT : S_PUSH1;
            S_QRD,
            S_QWALK:
            begin
                if (a_rdata.ar != 5'd0 || q_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_QWALK;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb
    begin
        op_next      = op_reg;
        rank_next    = rank_reg;
        page_next    = page_reg;
        c_next       = c_reg;
        blk_next     = blk_reg;
        cnt_next     = cnt_reg;
        unl_p_next   = unl_p_reg;
        unl_r_next   = unl_r_reg;
        psh_p_next   = psh_p_reg;
        psh_r_next   = psh_r_reg;
        psh_h_next   = psh_h_reg;
        nx_next      = nx_reg;
        pv_next      = pv_reg;
        act_next     = act_reg;
        clr_rsp_next = clr_rsp_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        a_raddr      = '0;
        b_raddr      = '0;
        a_wr         = '0;
        b_wr         = '0;
        lst_we_head  = 1'b0;
        lst_head_wd  = '0;
        lst_we_cnt   = 1'b0;
        lst_cnt_wd   = '0;
        init_lists   = 1'b0;

        case (state_reg)
            // command decode
            S_IDLE:
            begin
                a_raddr = cmd.page[PAGE_W-1:0];
                if (start)
                begin
                    op_next   = cmd.operation;
                    rank_next = cmd.rank;
                    c_next    = cmd.rank;
                    page_next = cmd.page[PAGE_W-1:0];
                    cnt_next  = '0;
                    rsp_next  = '0;
                    case (cmd.operation)
                        OP_INIT:
                        begin
                            act_next     = act_of(pool_rank_reg);
                            init_lists   = 1'b1;
                            clr_rsp_next = 1'b1;
                        end
                        OP_ALLOC:
                        begin
                            if (!cmd_rank_ok)
                            begin
                                rsp_next.status = STAT_INVALID;
                                done_next       = 1'b1;
                            end
                        end
                        OP_FREE,
                        OP_QRANK:
                        begin
                            if (!cmd_page_ok)
                            begin
                                rsp_next.status = STAT_INVALID;
                                done_next       = 1'b1;
                            end
                        end
                        OP_QCOUNT:
                        begin
                            if (cmd_rank_ok)
                            begin
                                rsp_next.value = lst_cnt;
                            end
                            else
                            begin
                                rsp_next.status = STAT_INVALID;
                            end
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            rsp_next.status = STAT_INVALID;
                            done_next       = 1'b1;
                        end
                    endcase
                end
            end

            // clearing pass, page zero becomes the whole free pool
            S_CLEAR:
            begin
                a_wr.en_alloc = 1'b1;
                a_wr.en_free  = 1'b1;
                a_wr.addr     = cnt_reg[PAGE_W-1:0];
                a_wr.data.fr  = (cnt_reg == '0) ? {1'b0, act_reg} : 5'd0;
                b_wr.en_nx    = cnt_reg == '0;
                b_wr.en_pv    = cnt_reg == '0;
                b_wr.data.nx  = LINK_NIL;
                b_wr.data.pv  = LINK_NIL;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (clr_last)
                begin
                    done_next    = clr_rsp_reg;
                    rsp_next     = '0;
                    clr_rsp_next = 1'b0;
                end
            end

            // alloc: lowest non-empty list at or above the rank
            S_ASRCH:
            begin
                b_raddr = lst_head[PAGE_W-1:0];
                if (!c_in_pool)
                begin
                    rsp_next.status = STAT_NOSPACE;
                    done_next       = 1'b1;
                end
                else if (lst_head[LINK_W-1])
                begin
                    c_next = c_reg + 5'd1;
                end
                else
                begin
                    blk_next   = lst_head[PAGE_W-1:0];
                    unl_p_next = lst_head[PAGE_W-1:0];
                    unl_r_next = c_reg;
                end
            end

            // unlink: predecessor side, clear free rank
            S_UNL_DAT:
            begin
                nx_next = b_rdata.nx;
                pv_next = b_rdata.pv;
                if (b_rdata.pv[LINK_W-1])
                begin
                    lst_we_head = 1'b1;
                    lst_head_wd = b_rdata.nx;
                end
                else
                begin
                    b_wr.en_nx   = 1'b1;
                    b_wr.addr    = b_rdata.pv[PAGE_W-1:0];
                    b_wr.data.nx = b_rdata.nx;
                end
                lst_we_cnt   = 1'b1;
                lst_cnt_wd   = lst_cnt - CNT_W'(1);
                a_wr.en_free = 1'b1;
                a_wr.addr    = unl_p_reg;
                a_wr.data.fr = 5'd0;
            end

            // unlink: successor side
            S_UNL_PV:
            begin
                if (!nx_reg[LINK_W-1])
                begin
                    b_wr.en_pv   = 1'b1;
                    b_wr.addr    = nx_reg[PAGE_W-1:0];
                    b_wr.data.pv = pv_reg;
                end
            end

            // alloc: split off the upper half
            S_ASPLIT:
            begin
                if (split_more)
                begin
                    c_next     = c_dn;
                    psh_p_next = split_p;
                    psh_r_next = c_dn;
                end
                else
                begin
                    cnt_next = '0;
                end
            end

            // push: new head and its links
            S_PUSH1:
            begin
                psh_h_next   = lst_head;
                b_wr.en_nx   = 1'b1;
                b_wr.en_pv   = 1'b1;
                b_wr.addr    = psh_p_reg;
                b_wr.data.nx = lst_head;
                b_wr.data.pv = LINK_NIL;
                a_wr.en_free = 1'b1;
                a_wr.addr    = psh_p_reg;
                a_wr.data.fr = psh_r_reg;
                lst_we_head  = 1'b1;
                lst_head_wd  = {1'b0, psh_p_reg};
                lst_we_cnt   = 1'b1;
                lst_cnt_wd   = lst_cnt + CNT_W'(1);
            end

            // push: back link of the old head
            S_PUSH2:
            begin
                if (!psh_h_reg[LINK_W-1])
                begin
                    b_wr.en_pv   = 1'b1;
                    b_wr.addr    = psh_h_reg[PAGE_W-1:0];
                    b_wr.data.pv = {1'b0, psh_p_reg};
                end
                if (op_reg != OP_ALLOC)
                begin
                    rsp_next.status = STAT_OK;
                    done_next       = 1'b1;
                end
            end

            // alloc: mark pages of the block
            S_AFILL:
            begin
                a_wr.en_alloc = 1'b1;
                a_wr.addr     = blk_reg + cnt_reg[PAGE_W-1:0];
                a_wr.data.ar  = rank_reg;
                a_wr.data.bs  = cnt_reg == '0;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (fill_last)
                begin
                    rsp_next.status   = STAT_OK;
                    rsp_next.page_out = blk_reg;
                    done_next         = 1'b1;
                end
            end

            // free: check block start
            S_FRD:
            begin
                if (a_rdata.bs)
                begin
                    c_next   = a_rdata.ar;
                    cnt_next = '0;
                    blk_next = page_reg;
                end
                else
                begin
                    rsp_next.status = STAT_INVALID;
                    done_next       = 1'b1;
                end
            end

            // free: clear pages of the block
            S_FCLR:
            begin
                a_wr.en_alloc = 1'b1;
                a_wr.addr     = page_reg + cnt_reg[PAGE_W-1:0];
                a_wr.data.ar  = 5'd0;
                a_wr.data.bs  = 1'b0;
                cnt_next      = cnt_reg + CNT_W'(1);
            end

            // free: look at the buddy
            S_FMRG:
            begin
                a_raddr    = buddy;
                unl_p_next = buddy;
                unl_r_next = c_reg;
                psh_p_next = blk_reg;
                psh_r_next = c_reg;
            end

            // free: merge when the buddy is free at the same rank
            S_FCHK:
            begin
                b_raddr = unl_p_reg;
                if (a_rdata.fr == c_reg)
                begin
                    blk_next = blk_reg & ~PAGE_W'(blk_pages(c_reg));
                    c_next   = c_reg + 5'd1;
                end
            end

            // query rank: rank of an allocated page, else of its run of unallocated pages
            S_QRD,
            S_QWALK:
            begin
                a_raddr = qsum[PAGE_W-1:0];
                if (a_rdata.ar != 5'd0)
                begin
                    rsp_next.value = (state_reg == S_QRD) ? {6'b0, a_rdata.ar}
                                                          : {6'b0, run_rank(cnt_reg)};
                    done_next      = 1'b1;
                end
                else if (q_end)
                begin
                    rsp_next.value = {6'b0, run_rank(cnt_reg + CNT_W'(1))};
                    done_next      = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            act_reg       <= ACT_MAX;
            pool_rank_reg <= ACT_MAX;
            clr_rsp_reg   <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < RANK_LIMIT; i++)
            begin
                head_reg[i]   <= (i == int'(ACT_MAX) - 1) ? '0 : LINK_NIL;
                lcount_reg[i] <= (i == int'(ACT_MAX) - 1) ? CNT_W'(1) : '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            act_reg     <= act_next;
            clr_rsp_reg <= clr_rsp_next;
            done_reg    <= done_next;
            if (cfg_valid)
            begin
                pool_rank_reg <= cfg_data;
            end
            if (init_lists)
            begin
                for (int i = 0; i < RANK_LIMIT; i++)
                begin
                    head_reg[i]   <= (i == int'(act_next) - 1) ? '0 : LINK_NIL;
                    lcount_reg[i] <= (i == int'(act_next) - 1) ? CNT_W'(1) : '0;
                end
            end
            else
            begin
                if (lst_we_head)
                begin
                    head_reg[lst_idx] <= lst_head_wd;
                end
                if (lst_we_cnt)
                begin
                    lcount_reg[lst_idx] <= lst_cnt_wd;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        rank_reg  <= rank_next;
        page_reg  <= page_next;
        c_reg     <= c_next;
        blk_reg   <= blk_next;
        unl_p_reg <= unl_p_next;
        unl_r_reg <= unl_r_next;
        psh_p_reg <= psh_p_next;
        psh_r_reg <= psh_r_next;
        psh_h_reg <= psh_h_next;
        nx_reg    <= nx_next;
        pv_reg    <= pv_next;
        rsp_reg   <= rsp_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the buddy page allocator core
// commands go through a queue-fed driver, a monitor checks every result
// against a behavioral allocator model kept in step with accepted commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import bpa_pkg::*;
;

    localparam int NIL_PAGE  = 32'hFFFF;
    localparam int CYCLE_CAP = 3000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    bpa_cmd_t cmd;
    logic     busy;
    logic     done;
    bpa_rsp_t result;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [3:0] cfg_data;

    buddy_page_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // allocator model state
    int pool_reg;
    int act_rank;
    int act_pages;
    int pg_alloc[POOL_PAGES];
    bit pg_start[POOL_PAGES];
    int pg_free[POOL_PAGES];
    int pg_next[POOL_PAGES];
    int pg_prev[POOL_PAGES];
    int head_of[RANK_LIMIT+1];
    int count_of[RANK_LIMIT+1];

    bpa_cmd_t cmd_queue[$];
    bpa_rsp_t rsp_queue[$];
    int       fail_count;
    int       cycle_count;
    int       idle_pct;
    bit       cfg_req;
    logic [3:0] cfg_val;

    function automatic void unlink_block(int p, int r);
        int pv;
        int nx;
        pv = pg_prev[p];
        nx = pg_next[p];
        if (pv == NIL_PAGE)
        begin
            head_of[r] = nx;
        end
        else
        begin
            pg_next[pv] = nx;
        end
        if (nx != NIL_PAGE)
        begin
            pg_prev[nx] = pv;
        end
        count_of[r]--;
        pg_free[p] = 0;
    endfunction

    function automatic void push_block(int p, int r);
        int h;
        h = head_of[r];
        pg_next[p] = h;
        pg_prev[p] = NIL_PAGE;
        if (h != NIL_PAGE)
        begin
            pg_prev[h] = p;
        end
        head_of[r] = p;
        count_of[r]++;
        pg_free[p] = r;
    endfunction

    function automatic void init_pool();
        int r;
        r = pool_reg;
        if (r < 1)
        begin
            r = 1;
        end
        while (r > 1 && (1 << (r - 1)) > POOL_PAGES)
        begin
            r--;
        end
        act_rank  = r;
        act_pages = 1 << (r - 1);
        for (int i = 0; i < POOL_PAGES; i++)
        begin
            pg_alloc[i] = 0;
            pg_start[i] = 0;
            pg_free[i]  = 0;
            pg_next[i]  = 0;
            pg_prev[i]  = 0;
        end
        for (int i = 0; i <= RANK_LIMIT; i++)
        begin
            head_of[i]  = NIL_PAGE;
            count_of[i] = 0;
        end
        push_block(0, act_rank);
    endfunction

    // predict the response of one command and update the model
    function automatic bpa_rsp_t alloc_predict(bpa_cmd_t c);
        bpa_rsp_t rsp;
        int       rk;
        int       pg;
        int       lvl;
        int       blk;
        int       bud;
        int       run;
        rsp = '0;
        rk  = c.rank;
        pg  = c.page;
        case (c.operation)
            OP_INIT:
            begin
                init_pool();
            end
            OP_ALLOC:
            begin
                if (rk < 1 || rk > RANK_LIMIT)
                begin
                    rsp.status = STAT_INVALID;
                end
                else
                begin
                    lvl = rk;
                    while (lvl <= act_rank && head_of[lvl] == NIL_PAGE)
                    begin
                        lvl++;
                    end
                    if (lvl > act_rank)
                    begin
                        rsp.status = STAT_NOSPACE;
                    end
                    else
                    begin
                        blk = head_of[lvl];
                        unlink_block(blk, lvl);
                        while (lvl > rk)
                        begin
                            lvl--;
                            push_block(blk + (1 << (lvl - 1)), lvl);
                        end
                        for (int i = 0; i < (1 << (rk - 1)); i++)
                        begin
                            pg_alloc[blk + i] = rk;
                        end
                        pg_start[blk] = 1;
                        rsp.page_out = blk[9:0];
                    end
                end
            end
            OP_FREE:
            begin
                if (pg >= act_pages || !pg_start[pg])
                begin
                    rsp.status = STAT_INVALID;
                end
                else
                begin
                    lvl = pg_alloc[pg];
                    for (int i = 0; i < (1 << (lvl - 1)); i++)
                    begin
                        pg_alloc[pg + i] = 0;
                    end
                    pg_start[pg] = 0;
                    blk = pg;
                    while (lvl < act_rank)
                    begin
                        bud = blk ^ (1 << (lvl - 1));
                        if (pg_free[bud] != lvl)
                        begin
                            break;
                        end
                        unlink_block(bud, lvl);
                        if (bud < blk)
                        begin
                            blk = bud;
                        end
                        lvl++;
                    end
                    push_block(blk, lvl);
                end
            end
            OP_QRANK:
            begin
                if (pg >= act_pages)
                begin
                    rsp.status = STAT_INVALID;
                end
                else if (pg_alloc[pg] != 0)
                begin
                    rsp.value = 11'(pg_alloc[pg]);
                end
                else
                begin
                    run = 0;
                    while (pg + run < act_pages && pg_alloc[pg + run] == 0)
                    begin
                        run++;
                    end
                    lvl = 1;
                    while (lvl < RANK_LIMIT && (1 << lvl) <= run)
                    begin
                        lvl++;
                    end
                    rsp.value = 11'(lvl);
                end
            end
            OP_QCOUNT:
            begin
                if (rk < 1 || rk > RANK_LIMIT)
                begin
                    rsp.status = STAT_INVALID;
                end
                else
                begin
                    rsp.value = 11'(count_of[rk]);
                end
            end
            default:
            begin
                rsp.status = STAT_INVALID;
            end
        endcase
        return rsp;
    endfunction

    function automatic bpa_cmd_t make_cmd(logic [2:0] op, logic [4:0] rk, logic [15:0] pg);
        bpa_cmd_t c;
        c.operation = op;
        c.rank      = rk;
        c.page      = pg;
        return c;
    endfunction

    // random command mostly well formed within the active pool
    function automatic bpa_cmd_t random_cmd();
        int       sel;
        bpa_cmd_t c;
        sel = $urandom_range(0, 99);
        c.rank = 5'($urandom_range(1, act_rank));
        c.page = 16'($urandom_range(0, act_pages - 1));
        if (sel < 40)
        begin
            c.operation = OP_ALLOC;
            if ($urandom_range(0, 3) != 0)
            begin
                c.rank = 5'($urandom_range(1, (act_rank > 4) ? 4 : act_rank));
            end
        end
        else if (sel < 75)
        begin
            c.operation = OP_FREE;
            if ($urandom_range(0, 3) != 0)
            begin
                c.page = 16'($urandom_range(0, act_pages - 1) & ~3);
            end
        end
        else if (sel < 85)
        begin
            c.operation = OP_QRANK;
        end
        else if (sel < 93)
        begin
            c.operation = OP_QCOUNT;
        end
        else if (sel < 94)
        begin
            c.operation = OP_INIT;
        end
        else
        begin
            // noise over the whole field space
            c = bpa_cmd_t'($urandom);
        end
        return c;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always #4 clk = ~clk;

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                rsp_queue.push_back(alloc_predict(cmd));
            end
            if (!(start && busy))
            begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= cmd_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // config driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pool_reg  = cfg_data;
            cfg_valid <= 1'b0;
            cfg_req   = 1'b0;
        end
        else if (cfg_req && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_val;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_queue.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                bpa_rsp_t exp_rsp;
                exp_rsp = rsp_queue.pop_front();
                if (result.status !== exp_rsp.status)
                begin
                    $error("status exp %0d got %0d", exp_rsp.status, result.status);
                    fail_count++;
                end
                if (result.page_out !== exp_rsp.page_out)
                begin
                    $error("page_out exp %0d got %0d", exp_rsp.page_out, result.page_out);
                    fail_count++;
                end
                if (result.value !== exp_rsp.value)
                begin
                    $error("value exp %0d got %0d", exp_rsp.value, result.value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (cmd_queue.size() > 0 || start || rsp_queue.size() > 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_pool(logic [3:0] v);
        cfg_val = v;
        cfg_req = 1'b1;
        while (cfg_req)
        begin
            @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        logic [3:0] ranks[6];
        int         pct[4];
        ranks = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd11, 4'd6};
        pct   = '{0, 47, 0, 9};
        fail_count  = 0;
        cycle_count = 0;
        idle_pct    = 0;
        cfg_req     = 1'b0;
        pool_reg    = 11;
        init_pool();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed commands on the reset pool
        cmd_queue.push_back(make_cmd(OP_QCOUNT, 5'd11, 16'd0));
        cmd_queue.push_back(make_cmd(OP_QRANK, 5'd0, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd0, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd17, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd31, 16'hFFFF));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd12, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd1, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd3, 16'd0));
        cmd_queue.push_back(make_cmd(OP_QRANK, 5'd0, 16'd1));
        cmd_queue.push_back(make_cmd(OP_QRANK, 5'd0, 16'd1023));
        cmd_queue.push_back(make_cmd(OP_QRANK, 5'd0, 16'd1024));
        cmd_queue.push_back(make_cmd(OP_FREE, 5'd0, 16'd5));
        cmd_queue.push_back(make_cmd(OP_FREE, 5'd0, 16'hFFFF));
        cmd_queue.push_back(make_cmd(OP_FREE, 5'd0, 16'd0));
        cmd_queue.push_back(make_cmd(OP_FREE, 5'd0, 16'd0));
        cmd_queue.push_back(make_cmd(OP_QCOUNT, 5'd16, 16'd0));
        cmd_queue.push_back(make_cmd(OP_QCOUNT, 5'd0, 16'd0));
        cmd_queue.push_back(make_cmd(3'd5, 5'd1, 16'd0));
        cmd_queue.push_back(make_cmd(3'd7, 5'd31, 16'hFFFF));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd11, 16'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 5'd1, 16'd0));
        cmd_queue.push_back(make_cmd(OP_FREE, 5'd0, 16'd4));
        cmd_queue.push_back(make_cmd(OP_INIT, 5'd0, 16'd0));
        drain();

        // random phases over several pool sizes and idling rates
        for (int ph = 0; ph < 6; ph++)
        begin
            set_pool(ranks[ph]);
            idle_pct = pct[ph % 4];
            cmd_queue.push_back(make_cmd(OP_INIT, 5'd0, 16'd0));
            drain();
            for (int n = 0; n < 95; n++)
            begin
                cmd_queue.push_back(random_cmd());
                if (cmd_queue[$].operation == OP_INIT)
                begin
                    drain();
                end
                while (cmd_queue.size() > 4)
                begin
                    @(posedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bpa_pkg.sv
sv/bpa_page_mem.sv
sv/bpa_link_mem.sv
sv/bpa_ctrl.sv
sv/buddy_page_allocator_core.sv
verif/testbench.sv
